FILE: hw/rtl/wsg_pkg.sv
// Shared types and constants for the Wiener spectral gain block.
`default_nettype none
package wsg_pkg;
  localparam int unsigned FrameBins = 256;
  localparam int unsigned BinW = $clog2(FrameBins);
  localparam int unsigned SumW = 40;
  localparam int unsigned SnrW = 24;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [SnrW-1:0] SnrMax = {SnrW{1'b1}};
  localparam logic [SnrW-1:0] FirstPrior = 24'd62259;
  localparam logic [15:0] AlphaReset = 16'd64225;
  localparam logic [7:0] NfReset = 8'd8;
  localparam int unsigned DivW = 64;

  typedef enum logic [1:0] {
    REQ_LEARN  = 2'd0,
    REQ_FILTER = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [0:0] {
    CFG_ALPHA = 1'b0,
    CFG_NFRAMES = 1'b1
  } cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_WIPE, ST_READ, ST_POWER, ST_LEARN, ST_MEAN, ST_MEAN_W, ST_POST, ST_POST_W,
    ST_PRIOR_A, ST_PRIOR_B, ST_GAIN, ST_GAIN_W, ST_SCALE_RE, ST_SCALE_IM,
    ST_M2_RE, ST_M2_IM, ST_Q, ST_Q_W, ST_WRITE, ST_OUT
  } state_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] num;
    logic [DivW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quo;
  } div_rsp_t;
endpackage
`default_nettype wire

FILE: hw/rtl/wsg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`default_nettype none
module wsg_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire wsg_pkg::div_req_t req_i,
  output wsg_pkg::div_rsp_t      rsp_o
);
  localparam int unsigned W = wsg_pkg::DivW;
  localparam int unsigned CW = $clog2(W);
  logic [W-1:0] quo_q, quo_d, rem_q, rem_d, den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic busy_q, busy_d, done_q, done_d;
  logic [W:0] trial;
  logic [W:0] shifted;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    shifted = {rem_q, quo_q[W-1]};
    trial = shifted - {1'b0, den_q};
    if (req_i.start) begin
      quo_d = req_i.num; rem_d = '0; den_d = req_i.den;
      cnt_d = '0; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[W]) begin
        rem_d = trial[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(W-1)) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
endmodule
`default_nettype wire

FILE: hw/rtl/wiener_spectral_gain.sv
// Top level: decision-directed Wiener gain per spectral bin, sequenced over one divider.
//
//  channel | dir | handshake            | payload (low bits first)
//  s_axis  | in  | s_axis_tvalid/tready | tdata: bin_re, bin_im; tuser: req_type
//  m_axis  | out | m_axis_tvalid/tready | tdata: out_re, out_im, gain, bin_index;
//          |     |                      | tuser: noise_zero, frame_end
//  cfg     | in  | cfg_we_i             | cfg_idx_i selects alpha / noise_frames
//
// A learn item runs through the read, power and learn states before the next accept. A filter
// item runs four 64-step divisions (noise mean, post SNR, gain, output SNR) on the shared
// restoring divider, plus single steps for accept, read, both squares, the prior update,
// scaling and output; a bin with zero noise mean ends after the first division.
// After reset and after each clear item a wipe pass runs, one
// bin per cycle over both per-bin memories; no input is taken meanwhile.
// A finished result sits in the output register while the next item is worked on;
// only the following result waits until that register has been transferred.
`default_nettype none
module wiener_spectral_gain (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // bin_re[15:0], bin_im[31:16]
  input  wire logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // out_re, out_im, gain, bin_index
  output logic [1:0]       m_axis_tuser,   // noise_zero[0], frame_end[1]
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  localparam int unsigned BW = wsg_pkg::BinW;
  localparam int unsigned SW = wsg_pkg::SumW;
  localparam int unsigned QW = wsg_pkg::SnrW;
  localparam int unsigned DW = wsg_pkg::DivW;

  // configuration
  logic [15:0] alpha_q;
  logic [7:0]  nf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= wsg_pkg::AlphaReset;
      nf_q    <= wsg_pkg::NfReset;
    end else if (cfg_we_i) begin
      case (wsg_pkg::cfg_e'(cfg_idx_i))
        wsg_pkg::CFG_ALPHA:   alpha_q <= cfg_data_i;
        wsg_pkg::CFG_NFRAMES: nf_q    <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // per-bin memories
  logic [SW-1:0] noise_mem [wsg_pkg::FrameBins];
  logic [QW-1:0] prior_mem [wsg_pkg::FrameBins];
  logic [SW-1:0] noise_rd_q;
  logic [QW-1:0] prior_rd_q;
  logic          mem_we;
  logic [BW-1:0] mem_addr;
  logic [SW-1:0] noise_wd;
  logic [QW-1:0] prior_wd;
  logic          noise_we, prior_we;

  always_ff @(posedge clk_i) begin
    if (noise_we) noise_mem[mem_addr] <= noise_wd;
    if (prior_we) prior_mem[mem_addr] <= prior_wd;
    noise_rd_q <= noise_mem[mem_addr];
    prior_rd_q <= prior_mem[mem_addr];
  end

  // divider
  wsg_pkg::div_req_t div_req;
  wsg_pkg::div_rsp_t div_rsp;
  wsg_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // control and datapath registers
  wsg_pkg::state_e state_q, state_d;
  logic [BW-1:0] k_q, k_d, wipe_q, wipe_d;
  logic          first_q, first_d, mvalid_q, mvalid_d;
  wsg_pkg::req_e req_q, req_d;
  logic signed [15:0] re_q, re_d, im_q, im_d;
  logic [32:0] pow_q, pow_d;
  logic [SW-1:0] mean_q, mean_d;
  logic [DW-1:0] acc_q, acc_d;
  logic [15:0] g_q, g_d;
  logic signed [15:0] ore_q, ore_d, oim_q, oim_d;
  logic [55:0] mdata_q, mdata_d;
  logic [1:0]  muser_q, muser_d;

  // shared multiplier: one 33x17 product per cycle
  logic [32:0] mul_a;
  logic [16:0] mul_b;
  logic [49:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [15:0] mag;
  logic        neg;
  logic [SW:0] sum_tmp;
  logic [DW-1:0] post_sat;
  logic [15:0] rnd;
  logic        last;
  assign last = (k_q == BW'(wsg_pkg::FrameBins - 1));

  always_comb begin
    state_d = state_q; k_d = k_q; wipe_d = wipe_q; first_d = first_q;
    mvalid_d = mvalid_q; req_d = req_q; re_d = re_q; im_d = im_q;
    pow_d = pow_q; mean_d = mean_q; acc_d = acc_q; g_d = g_q;
    ore_d = ore_q; oim_d = oim_q; mdata_d = mdata_q; muser_d = muser_q;
    s_axis_tready = 1'b0;
    div_req = '0;
    noise_we = 1'b0; prior_we = 1'b0;
    noise_wd = '0; prior_wd = '0;
    mem_addr = k_q;
    mul_a = '0; mul_b = '0;
    mag = '0; neg = 1'b0; sum_tmp = '0; post_sat = '0; rnd = '0;
    if (mvalid_q && m_axis_tready) mvalid_d = 1'b0;
    case (state_q)
      wsg_pkg::ST_WIPE: begin
        mem_addr = wipe_q; noise_we = 1'b1; prior_we = 1'b1;
        wipe_d = wipe_q + 1'b1;
        if (wipe_q == BW'(wsg_pkg::FrameBins - 1)) state_d = wsg_pkg::ST_IDLE;
      end
      wsg_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          req_d = wsg_pkg::req_e'(s_axis_tuser);
          re_d = s_axis_tdata[15:0]; im_d = s_axis_tdata[31:16];
          case (wsg_pkg::req_e'(s_axis_tuser))
            wsg_pkg::REQ_CLEAR: begin
              k_d = '0; first_d = 1'b1; wipe_d = '0; state_d = wsg_pkg::ST_WIPE;
            end
            wsg_pkg::REQ_LEARN, wsg_pkg::REQ_FILTER: state_d = wsg_pkg::ST_READ;
            default: ;
          endcase
        end
      end
      wsg_pkg::ST_READ: begin
        // memory read lands; square re
        mag = re_q[15] ? 16'(-re_q) : re_q;
        mul_a = 33'(mag); mul_b = 17'(mag);
        pow_d = mul_p[32:0];
        state_d = wsg_pkg::ST_POWER;
      end
      wsg_pkg::ST_POWER: begin
        mag = im_q[15] ? 16'(-im_q) : im_q;
        mul_a = 33'(mag); mul_b = 17'(mag);
        pow_d = pow_q + mul_p[32:0];
        state_d = (req_q == wsg_pkg::REQ_LEARN) ? wsg_pkg::ST_LEARN : wsg_pkg::ST_MEAN;
      end
      wsg_pkg::ST_LEARN: begin
        sum_tmp = {1'b0, noise_rd_q} + (SW+1)'(pow_q);
        noise_we = 1'b1;
        noise_wd = sum_tmp[SW] ? wsg_pkg::SumMax : sum_tmp[SW-1:0];
        k_d = last ? '0 : k_q + 1'b1;
        state_d = wsg_pkg::ST_IDLE;
      end
      wsg_pkg::ST_MEAN: begin
        div_req.start = 1'b1;
        div_req.num = DW'(noise_rd_q);
        div_req.den = (nf_q == 8'd0) ? DW'(1) : DW'(nf_q);
        state_d = wsg_pkg::ST_MEAN_W;
      end
      wsg_pkg::ST_MEAN_W: begin
        if (div_rsp.done) begin
          mean_d = div_rsp.quo[SW-1:0];
          if (div_rsp.quo == '0) begin
            prior_we = 1'b1; prior_wd = wsg_pkg::SnrMax;
            g_d = 16'hFFFF; ore_d = re_q; oim_d = im_q;
            state_d = wsg_pkg::ST_OUT;
          end else state_d = wsg_pkg::ST_POST;
        end
      end
      wsg_pkg::ST_POST: begin
        div_req.start = 1'b1;
        div_req.num = DW'({pow_q, 16'd0});
        div_req.den = DW'(mean_q);
        state_d = wsg_pkg::ST_POST_W;
      end
      wsg_pkg::ST_POST_W: begin
        if (div_rsp.done) begin
          post_sat = (div_rsp.quo > DW'(wsg_pkg::SnrMax)) ? DW'(wsg_pkg::SnrMax) : div_rsp.quo;
          // d = max(post-1,0), times (65536-alpha)
          mul_a = (post_sat > DW'(65536)) ? 33'(post_sat - DW'(65536)) : '0;
          mul_b = 17'h10000 - 17'(alpha_q);
          acc_d = DW'(mul_p) + DW'(32768);
          state_d = wsg_pkg::ST_PRIOR_A;
        end
      end
      wsg_pkg::ST_PRIOR_A: begin
        mul_a = first_q ? 33'(wsg_pkg::FirstPrior) : 33'(prior_rd_q);
        mul_b = 17'(alpha_q);
        acc_d = acc_q + DW'(mul_p);
        state_d = wsg_pkg::ST_PRIOR_B;
      end
      wsg_pkg::ST_PRIOR_B: begin
        acc_d = (acc_q[DW-1:16] > DW'(wsg_pkg::SnrMax)) ? DW'(wsg_pkg::SnrMax)
                                                        : DW'(acc_q[DW-1:16]);
        state_d = wsg_pkg::ST_GAIN;
      end
      wsg_pkg::ST_GAIN: begin
        div_req.start = 1'b1;
        div_req.num = DW'({acc_q[QW-1:0], 16'd0});
        div_req.den = DW'(acc_q[QW-1:0]) + DW'(65536);
        state_d = wsg_pkg::ST_GAIN_W;
      end
      wsg_pkg::ST_GAIN_W: begin
        if (div_rsp.done) begin
          g_d = (div_rsp.quo > DW'(16'hFFFF)) ? 16'hFFFF : div_rsp.quo[15:0];
          state_d = wsg_pkg::ST_SCALE_RE;
        end
      end
      wsg_pkg::ST_SCALE_RE, wsg_pkg::ST_SCALE_IM: begin
        neg = (state_q == wsg_pkg::ST_SCALE_RE) ? re_q[15] : im_q[15];
        mag = (state_q == wsg_pkg::ST_SCALE_RE) ? (re_q[15] ? 16'(-re_q) : re_q)
                                                : (im_q[15] ? 16'(-im_q) : im_q);
        mul_a = 33'(mag); mul_b = 17'(g_q);
        rnd = 16'((mul_p + 50'd32768) >> 16);
        if (state_q == wsg_pkg::ST_SCALE_RE) begin
          ore_d = neg ? 16'(-rnd) : rnd; state_d = wsg_pkg::ST_SCALE_IM;
        end else begin
          oim_d = neg ? 16'(-rnd) : rnd; state_d = wsg_pkg::ST_M2_RE;
        end
      end
      wsg_pkg::ST_M2_RE: begin
        mag = ore_q[15] ? 16'(-ore_q) : ore_q;
        mul_a = 33'(mag); mul_b = 17'(mag);
        pow_d = mul_p[32:0];
        state_d = wsg_pkg::ST_M2_IM;
      end
      wsg_pkg::ST_M2_IM: begin
        mag = oim_q[15] ? 16'(-oim_q) : oim_q;
        mul_a = 33'(mag); mul_b = 17'(mag);
        pow_d = pow_q + mul_p[32:0];
        state_d = wsg_pkg::ST_Q;
      end
      wsg_pkg::ST_Q: begin
        div_req.start = 1'b1;
        div_req.num = DW'({pow_q, 16'd0});
        div_req.den = DW'(mean_q);
        state_d = wsg_pkg::ST_Q_W;
      end
      wsg_pkg::ST_Q_W: begin
        if (div_rsp.done) begin
          prior_we = 1'b1;
          prior_wd = (div_rsp.quo > DW'(wsg_pkg::SnrMax)) ? wsg_pkg::SnrMax
                                                          : div_rsp.quo[QW-1:0];
          state_d = wsg_pkg::ST_OUT;
        end
      end
      wsg_pkg::ST_OUT: begin
        // load only once the output register is empty or drains this cycle
        if (!mvalid_q || m_axis_tready) begin
          mdata_d = {k_q[7:0], g_q, oim_q, ore_q};
          muser_d = {last, (mean_q == '0)};
          mvalid_d = 1'b1;
          if (last) first_d = 1'b0;
          k_d = last ? '0 : k_q + 1'b1;
          state_d = wsg_pkg::ST_IDLE;
        end
      end
      default: state_d = wsg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wsg_pkg::ST_WIPE; k_q <= '0; wipe_q <= '0;
      first_q <= 1'b1; mvalid_q <= 1'b0; req_q <= wsg_pkg::REQ_NONE;
    end else begin
      state_q <= state_d; k_q <= k_d; wipe_q <= wipe_d;
      first_q <= first_d; mvalid_q <= mvalid_d; req_q <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    re_q <= re_d; im_q <= im_d; pow_q <= pow_d; mean_q <= mean_d;
    acc_q <= acc_d; g_q <= g_d; ore_q <= ore_d; oim_q <= oim_d;
    mdata_q <= mdata_d; muser_q <= muser_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;
  assign mem_we = noise_we | prior_we;

  // assertions
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != wsg_pkg::ST_IDLE) |-> !s_axis_tready) else $error("accept while busy");
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mvalid_q && !m_axis_tready) |=>
      (mvalid_q && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled result changed");
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted");
  a_wipe_no_we: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == wsg_pkg::ST_IDLE) |-> !mem_we) else $error("memory write in idle");
endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for wiener_spectral_gain: bin-level gain predictor, scoreboard, stream drivers.
`default_nettype none

// One output bin as it leaves the master side.
typedef struct {
  logic signed [15:0] out_re;
  logic signed [15:0] out_im;
  logic [15:0]        gain;
  logic [7:0]         bin_index;
  logic               noise_zero;
  logic               frame_end;
} gain_bin_t;

class gain_scoreboard;
  logic [15:0]  alpha;
  logic [7:0]   noise_frames;
  logic [39:0]  noise_sum [256];
  logic [23:0]  prior_snr [256];
  logic [7:0]   bin_ctr;
  logic         first_frame;
  gain_bin_t    expected_bins [$];
  int           errors;

  function new();
    alpha = wsg_pkg::AlphaReset;
    noise_frames = wsg_pkg::NfReset;
    wipe();
    errors = 0;
  endfunction

  function void wipe();
    foreach (noise_sum[i]) begin
      noise_sum[i] = '0;
      prior_snr[i] = '0;
    end
    bin_ctr = '0;
    first_frame = 1'b1;
  endfunction

  function void write_reg(wsg_pkg::cfg_e idx, logic [15:0] val);
    if (idx == wsg_pkg::CFG_ALPHA) alpha = val;
    else noise_frames = val[7:0];
  endfunction

  // Magnitude times gain, rounded half away from zero.
  function automatic logic signed [15:0] scale_part(int v, longint unsigned g);
    longint unsigned mag;
    longint unsigned r;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    r = (mag * g + 32768) >> 16;
    return 16'((v < 0) ? -int'(r) : int'(r));
  endfunction

  function void report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endfunction

  // Accepted input transfer: advance the bin state and queue any result.
  function void note_bin(wsg_pkg::req_e req, logic signed [15:0] re, logic signed [15:0] im);
    longint unsigned power, mean, post, d, prev, snr, g, m2, q, s, nf;
    logic [7:0] k;
    logic last;
    gain_bin_t b;
    k = bin_ctr;
    last = (k == 8'd255);
    power = longint'(int'(re) * int'(re)) + longint'(int'(im) * int'(im));
    case (req)
      wsg_pkg::REQ_CLEAR: wipe();
      wsg_pkg::REQ_LEARN: begin
        s = noise_sum[k] + power;
        noise_sum[k] = (s > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : s[39:0];
        bin_ctr = k + 8'd1;
      end
      wsg_pkg::REQ_FILTER: begin
        nf = (noise_frames == 0) ? 1 : noise_frames;
        mean = noise_sum[k] / nf;
        b.bin_index = k;
        b.frame_end = last;
        b.noise_zero = (mean == 0);
        if (mean == 0) begin
          b.gain = 16'hFFFF;
          b.out_re = re;
          b.out_im = im;
          prior_snr[k] = wsg_pkg::SnrMax;
        end else begin
          post = (power << 16) / mean;
          if (post > 64'hFF_FFFF) post = 64'hFF_FFFF;
          d = (post > 65536) ? post - 65536 : 0;
          prev = first_frame ? wsg_pkg::FirstPrior : prior_snr[k];
          snr = (alpha * prev + (65536 - alpha) * d + 32768) >> 16;
          if (snr > 64'hFF_FFFF) snr = 64'hFF_FFFF;
          g = (snr << 16) / (65536 + snr);
          if (g > 65535) g = 65535;
          b.gain = g[15:0];
          b.out_re = scale_part(re, g);
          b.out_im = scale_part(im, g);
          m2 = longint'(int'(b.out_re) * int'(b.out_re))
             + longint'(int'(b.out_im) * int'(b.out_im));
          q = (m2 << 16) / mean;
          prior_snr[k] = (q > 64'hFF_FFFF) ? wsg_pkg::SnrMax : q[23:0];
        end
        expected_bins = {expected_bins, b};
        if (last) first_frame = 1'b0;
        bin_ctr = k + 8'd1;
      end
      default: ;  // unused request code: ignored
    endcase
  endfunction

  function void check_bin(gain_bin_t got);
    gain_bin_t e;
    if (expected_bins.size() == 0) begin
      report($sformatf("unexpected result bin %0d", got.bin_index));
      return;
    end
    e = expected_bins.pop_front();
    if (got.out_re !== e.out_re)
      report($sformatf("bin %0d out_re %0d exp %0d", e.bin_index, got.out_re, e.out_re));
    if (got.out_im !== e.out_im)
      report($sformatf("bin %0d out_im %0d exp %0d", e.bin_index, got.out_im, e.out_im));
    if (got.gain !== e.gain)
      report($sformatf("bin %0d gain %0d exp %0d", e.bin_index, got.gain, e.gain));
    if (got.bin_index !== e.bin_index)
      report($sformatf("bin_index %0d exp %0d", got.bin_index, e.bin_index));
    if (got.noise_zero !== e.noise_zero)
      report($sformatf("bin %0d noise_zero %0b exp %0b", e.bin_index, got.noise_zero,
                       e.noise_zero));
    if (got.frame_end !== e.frame_end)
      report($sformatf("bin %0d frame_end %0b exp %0b", e.bin_index, got.frame_end,
                       e.frame_end));
  endfunction
endclass

module tb_top;
  localparam int unsigned CycleLimit = 2000000;
  // Covers a clear item's wipe pass or a filter item in flight.
  localparam int unsigned SettleCycles = 400;
  localparam int ItemTarget = 500;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // bin_re[15:0], bin_im[31:16]
  logic [1:0]  s_axis_tuser = '0;    // req_type[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;         // out_re, out_im, gain, bin_index
  logic [1:0]  m_axis_tuser;         // noise_zero[0], frame_end[1]
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  gain_scoreboard sb = new();
  bit      idling_on = 1'b1;   // random bursts on both sides; off near the end
  int      sink_stall = 0;
  int      cycles = 0;
  int      items_sent = 0;

  wiener_spectral_gain i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Monitor: both sides sampled at the edge, before this edge's updates land.
  always @(posedge clk_i) begin
    gain_bin_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_bin(wsg_pkg::req_e'(s_axis_tuser), s_axis_tdata[15:0], s_axis_tdata[31:16]);
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_re = m_axis_tdata[15:0];
        got.out_im = m_axis_tdata[31:16];
        got.gain = m_axis_tdata[47:32];
        got.bin_index = m_axis_tdata[55:48];
        got.noise_zero = m_axis_tuser[0];
        got.frame_end = m_axis_tuser[1];
        sb.check_bin(got);
      end
    end
  end

  // Receiver: ready drops in short random bursts while idling is on.
  always @(posedge clk_i) begin
    if (sink_stall > 0) begin
      sink_stall <= sink_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      sink_stall <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // One input transfer; valid drops after it, and while idling is on a random gap sometimes comes before it.
  task automatic send_bin(wsg_pkg::req_e req, logic [15:0] re, logic [15:0] im);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      @(posedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end else begin
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {im, re};
    items_sent++;
    do @(posedge clk_i); while (!s_axis_tready);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic write_cfg(wsg_pkg::cfg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    sb.write_reg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (sb.expected_bins.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Random sample with a random amplitude so SNRs spread widely.
  function automatic logic [15:0] rand_part();
    logic signed [15:0] v;
    v = 16'($urandom);
    return v >>> $urandom_range(0, 15);
  endfunction

  initial begin
    int phase;
    int n;
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();  // lets the post-reset wipe pass finish

    // Directed: extremes with no noise learned, the unused code, clear.
    send_bin(wsg_pkg::REQ_LEARN, 16'h8000, 16'h7FFF);
    send_bin(wsg_pkg::REQ_LEARN, 16'h7FFF, 16'h8000);
    send_bin(wsg_pkg::REQ_LEARN, 16'hFFFF, 16'h0001);
    send_bin(wsg_pkg::REQ_LEARN, 16'h0000, 16'h0000);
    send_bin(wsg_pkg::REQ_FILTER, 16'h8000, 16'h8000);
    send_bin(wsg_pkg::REQ_FILTER, 16'h7FFF, 16'h7FFF);
    send_bin(wsg_pkg::REQ_FILTER, 16'h0000, 16'h0000);
    send_bin(wsg_pkg::REQ_NONE, 16'h1234, 16'h5678);
    send_bin(wsg_pkg::REQ_FILTER, 16'hFFFF, 16'h0001);
    send_bin(wsg_pkg::REQ_CLEAR, 16'hFFFF, 16'hFFFF);
    send_bin(wsg_pkg::REQ_FILTER, 16'h8000, 16'h7FFF);
    drain();

    // One frame of noise, then phases of register settings over mixed traffic.
    send_bin(wsg_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
    repeat (256) send_bin(wsg_pkg::REQ_LEARN, rand_part(), rand_part());
    drain();

    phase = 0;
    while (items_sent < ItemTarget) begin
      case (phase)
        0: begin
          write_cfg(wsg_pkg::CFG_ALPHA, 16'd0);
          write_cfg(wsg_pkg::CFG_NFRAMES, 16'd1);
        end
        1: begin
          write_cfg(wsg_pkg::CFG_ALPHA, 16'hFFFF);
          write_cfg(wsg_pkg::CFG_NFRAMES, 16'd255);
        end
        2: begin
          write_cfg(wsg_pkg::CFG_ALPHA, 16'd64225);
          write_cfg(wsg_pkg::CFG_NFRAMES, 16'd0);
        end
        default: begin
          write_cfg(wsg_pkg::CFG_ALPHA, 16'($urandom));
          write_cfg(wsg_pkg::CFG_NFRAMES, 16'($urandom_range(0, 255)));
        end
      endcase
      n = $urandom_range(40, 80);
      for (int i = 0; i < n && items_sent < ItemTarget; i++) begin
        if (items_sent > ItemTarget - 60) idling_on = 1'b0;
        r = $urandom_range(0, 99);
        if (r < 2) send_bin(wsg_pkg::REQ_NONE, 16'($urandom), 16'($urandom));
        else if (r < 5) send_bin(wsg_pkg::REQ_LEARN, rand_part(), rand_part());
        else if (r == 5) send_bin(wsg_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
        else send_bin(wsg_pkg::REQ_FILTER, rand_part(), rand_part());
      end
      drain();
      phase++;
    end

    drain();
    if (sb.expected_bins.size() != 0)
      sb.report($sformatf("%0d result bins never arrived", sb.expected_bins.size()));
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

`default_nettype wire
